// ===== rtl/lprf_pkg.sv =====
`timescale 1ns / 1ps

package lprf_pkg;

	localparam int BUFFER_BYTES_DEF = 4096;
	localparam int MAX_RECORD_DEF   = 64;

	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_POP   = 3'd1;
	localparam logic [2:0] OP_PEEK  = 3'd2;
	localparam logic [2:0] OP_CLEAR = 3'd3;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_EMPTY    = 3'd1;
	localparam logic [2:0] STS_NO_SPACE = 3'd2;
	localparam logic [2:0] STS_OVER     = 3'd3;
	localparam logic [2:0] STS_BAD_LEN  = 3'd4;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] data_byte;
		logic       first_of_record;
		logic [6:0] record_length;
		logic [6:0] reader_capacity;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_byte;
		logic [6:0]  stored_length;
		logic [11:0] free_bytes;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		K_PUSH  = 2'd0,
		K_FETCH = 2'd1,
		K_CLEAR = 2'd2,
		K_QUERY = 2'd3
	} cmd_kind_t;

	// decoded command as it waits between front and back
	typedef struct packed {
		cmd_kind_t  kind;
		logic       advance;
		logic       first_of_record;
		logic [7:0] data_byte;
		logic [6:0] record_length;
		logic [6:0] reader_capacity;
	} ent_t;

endpackage

// ===== rtl/lprf_front.sv =====
`timescale 1ns / 1ps

module lprf_front import lprf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  in_item_t cmd,
	output ent_t     head,
	output logic     head_valid,
	input  logic     pop
);

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	ent_t             ent_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;
	logic             push_q;
	ent_t             dec;

	function automatic ent_t classify(input in_item_t it);
		ent_t e;
		e.advance         = 1'b0;
		e.first_of_record = it.first_of_record;
		e.data_byte       = it.data_byte;
		e.record_length   = it.record_length;
		e.reader_capacity = it.reader_capacity;
		case (it.operation)
			OP_PUSH: begin
				e.kind = K_PUSH;
			end
			OP_POP: begin
				e.kind    = K_FETCH;
				e.advance = 1'b1;
			end
			OP_PEEK: begin
				e.kind = K_FETCH;
			end
			OP_CLEAR: begin
				e.kind = K_CLEAR;
			end
			default: begin
				e.kind = K_QUERY;
			end
		endcase
		return e;
	endfunction

	assign dec        = classify(cmd);
	assign cmd_ready  = (cnt_q != QCW'(QDEPTH));
	assign push_q     = cmd_valid && cmd_ready;
	assign head       = ent_q[rd_q];
	assign head_valid = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push_q) begin
			ent_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_q) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			case ({push_q, pop})
				2'b10: cnt_q <= cnt_q + QCW'(1);
				2'b01: cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/lprf_back.sv =====
`timescale 1ns / 1ps

module lprf_back import lprf_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int MAX_RECORD   = MAX_RECORD_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ent_t      head,
	input  logic      head_valid,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam int SW = AW + 8;
	localparam logic [SW-1:0] DEPTH = SW'(BUFFER_BYTES);
	localparam logic [15:0]   MAXR  = 16'(MAX_RECORD);

	typedef enum logic [4:0] {
		S_IDLE       = 5'b00001,
		S_PUSH_HI    = 5'b00010,
		S_PUSH_DATA  = 5'b00100,
		S_FETCH_CHK  = 5'b01000,
		S_FETCH_DATA = 5'b10000
	} bstate_t;

	// sums stay below twice the depth, so one subtract wraps them
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [SW-1:0] k);
		logic [SW-1:0] s;
		s = SW'(p) + k;
		if (s >= DEPTH) begin
			s = s - DEPTH;
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] free_of(input logic [AW-1:0] w, input logic [AW-1:0] r);
		logic [SW-1:0] d;
		if (w < r) begin
			d = SW'(r) - SW'(w);
		end else begin
			d = SW'(r) + DEPTH - SW'(w);
		end
		d = d - SW'(1);
		return d[AW-1:0];
	endfunction

	logic [7:0]    ring_q [BUFFER_BYTES];
	logic [7:0]    rd0_q;
	logic [7:0]    rd1_q;

	bstate_t       state_q, state_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [AW-1:0] rp_q, rp_d;
	logic [AW-1:0] pend_q, pend_d;
	logic [6:0]    rem_q, rem_d;
	logic          open_q, open_d;
	logic          rej_q, rej_d;
	logic [AW-1:0] base_q, base_d;
	logic [6:0]    len_q, len_d;
	logic [6:0]    idx_q, idx_d;
	logic          res_valid_q;
	out_item_t     res_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [AW-1:0] raddr0;
	logic [AW-1:0] raddr1;
	logic          out_free;
	logic          emit;
	logic [2:0]    e_status;
	logic [7:0]    e_byte;
	logic [6:0]    e_len;
	logic          e_last;

	logic          len_bad;
	logic          fits;
	logic [6:0]    rem_first;
	logic [6:0]    rem_next;
	logic [AW-1:0] pend_next;
	logic [15:0]   hlen;
	logic [6:0]    hlen7;
	logic          data_last;

	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign len_bad   = (head.record_length == 7'd0) || (16'(head.record_length) > MAXR);
	assign fits      = SW'(free_of(wp_q, rp_q)) >= (SW'(head.record_length) + SW'(2));
	assign rem_first = (head.record_length != 7'd0) ? head.record_length - 7'd1 : 7'd0;
	assign rem_next  = (rem_q != 7'd0) ? rem_q - 7'd1 : 7'd0;
	assign pend_next = wrap_add(pend_q, SW'(1));
	assign hlen      = {rd1_q, rd0_q};
	assign hlen7     = hlen[6:0];
	assign data_last = (idx_q == len_q - 7'd1);

	always_comb begin
		state_d  = state_q;
		wp_d     = wp_q;
		rp_d     = rp_q;
		pend_d   = pend_q;
		rem_d    = rem_q;
		open_d   = open_q;
		rej_d    = rej_q;
		base_d   = base_q;
		len_d    = len_q;
		idx_d    = idx_q;
		we       = 1'b0;
		waddr    = wp_q;
		wdata    = 8'd0;
		raddr0   = rp_q;
		raddr1   = wrap_add(rp_q, SW'(1));
		emit     = 1'b0;
		e_status = STS_OK;
		e_byte   = 8'd0;
		e_len    = 7'd0;
		e_last   = 1'b1;
		pop      = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					case (head.kind)
						K_PUSH: begin
							if (head.first_of_record) begin
								if (len_bad || !fits) begin
									if (out_free) begin
										emit     = 1'b1;
										pop      = 1'b1;
										e_status = len_bad ? STS_OVER : STS_NO_SPACE;
										open_d   = (rem_first != 7'd0);
										rej_d    = 1'b1;
										rem_d    = rem_first;
									end
								end else begin
									// low header byte now, high byte and data next
									we      = 1'b1;
									waddr   = wp_q;
									wdata   = {1'b0, head.record_length};
									open_d  = 1'b1;
									rej_d   = 1'b0;
									rem_d   = rem_first;
									pend_d  = wp_q;
									state_d = S_PUSH_HI;
								end
							end else if (out_free) begin
								emit = 1'b1;
								pop  = 1'b1;
								if (!open_q) begin
									e_status = STS_NO_SPACE;
								end else begin
									rem_d = rem_next;
									if (rej_q) begin
										e_status = STS_NO_SPACE;
										open_d   = (rem_next != 7'd0);
									end else begin
										we     = 1'b1;
										waddr  = pend_q;
										wdata  = head.data_byte;
										pend_d = pend_next;
										if (rem_next == 7'd0) begin
											wp_d   = pend_next;
											open_d = 1'b0;
										end
									end
								end
							end
						end
						K_FETCH: begin
							if (rp_q == wp_q) begin
								if (out_free) begin
									emit     = 1'b1;
									pop      = 1'b1;
									e_status = STS_EMPTY;
								end
							end else begin
								state_d = S_FETCH_CHK;
							end
						end
						K_CLEAR: begin
							if (out_free) begin
								emit   = 1'b1;
								pop    = 1'b1;
								wp_d   = '0;
								rp_d   = '0;
								pend_d = '0;
								rem_d  = 7'd0;
								open_d = 1'b0;
								rej_d  = 1'b0;
							end
						end
						default: begin
							if (out_free) begin
								emit = 1'b1;
								pop  = 1'b1;
							end
						end
					endcase
				end
			end
			S_PUSH_HI: begin
				we      = 1'b1;
				waddr   = wrap_add(pend_q, SW'(1));
				wdata   = 8'd0;
				state_d = S_PUSH_DATA;
			end
			S_PUSH_DATA: begin
				if (out_free) begin
					we     = 1'b1;
					waddr  = wrap_add(pend_q, SW'(2));
					wdata  = head.data_byte;
					pend_d = wrap_add(pend_q, SW'(3));
					if (rem_q == 7'd0) begin
						wp_d   = wrap_add(pend_q, SW'(3));
						open_d = 1'b0;
					end
					emit    = 1'b1;
					pop     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FETCH_CHK: begin
				if (hlen == 16'd0 || hlen > MAXR) begin
					if (out_free) begin
						emit     = 1'b1;
						pop      = 1'b1;
						e_status = STS_BAD_LEN;
						state_d  = S_IDLE;
					end
				end else if (head.reader_capacity != 7'd0 && hlen7 > head.reader_capacity) begin
					if (out_free) begin
						emit     = 1'b1;
						pop      = 1'b1;
						e_status = STS_OVER;
						e_len    = hlen7;
						state_d  = S_IDLE;
					end
				end else if (head.reader_capacity == 7'd0) begin
					if (out_free) begin
						emit    = 1'b1;
						pop     = 1'b1;
						e_len   = hlen7;
						state_d = S_IDLE;
						if (head.advance) begin
							rp_d = wrap_add(rp_q, SW'(2) + SW'(hlen7));
						end
					end
				end else begin
					base_d  = wrap_add(rp_q, SW'(2));
					raddr0  = wrap_add(rp_q, SW'(2));
					len_d   = hlen7;
					idx_d   = 7'd0;
					state_d = S_FETCH_DATA;
					if (head.advance) begin
						rp_d = wrap_add(rp_q, SW'(2) + SW'(hlen7));
					end
				end
			end
			S_FETCH_DATA: begin
				// re-read the same byte while the output stalls
				raddr0 = wrap_add(base_q, SW'(idx_q));
				if (out_free) begin
					emit   = 1'b1;
					e_byte = rd0_q;
					e_len  = len_q;
					e_last = data_last;
					raddr0 = wrap_add(base_q, SW'(idx_q) + SW'(1));
					idx_d  = idx_q + 7'd1;
					if (data_last) begin
						pop     = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ring_q[waddr] <= wdata;
		end
		rd0_q <= ring_q[raddr0];
		rd1_q <= ring_q[raddr1];
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
		len_q  <= len_d;
		idx_q  <= idx_d;
		if (emit) begin
			res_q.status        <= e_status;
			res_q.out_byte      <= e_byte;
			res_q.stored_length <= e_len;
			res_q.free_bytes    <= 12'(free_of(wp_d, rp_d));
			res_q.last          <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			pend_q      <= '0;
			rem_q       <= 7'd0;
			open_q      <= 1'b0;
			rej_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			pend_q  <= pend_d;
			rem_q   <= rem_d;
			open_q  <= open_d;
			rej_q   <= rej_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/length_prefixed_record_ring_fifo_unit.sv =====
// result path: queued in the front, registered in the back, held while the output stalls
// throughput: one item per cycle for push bytes, clear and query while the output is free;
// an accepted first byte uses S_IDLE, S_PUSH_HI, S_PUSH_DATA, as one port also writes headers
// pop/peek: the header is read in S_IDLE and checked in S_FETCH_CHK (an empty ring answers
// from S_IDLE), then payload bytes come from S_FETCH_DATA, held while the output stalls
// reset: arst_n clears pointers, push state, queue and output valid; store contents undefined
`timescale 1ns / 1ps

module length_prefixed_record_ring_fifo_unit import lprf_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int MAX_RECORD   = MAX_RECORD_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  in_item_t  cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	ent_t head;
	logic head_valid;
	logic pop;

	lprf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	lprf_back #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MAX_RECORD   (MAX_RECORD)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

`ifndef SYNTHESIS
	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> head_valid)
		else $error("front stalls with no queued item");

	a_bad_len_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == STS_BAD_LEN) |-> (res.stored_length == 7'd0 && res.last))
		else $error("bad stored length result malformed");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == STS_EMPTY) |-> (res.stored_length == 7'd0 && res.last))
		else $error("empty result malformed");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import lprf_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TAIL_CYCLES  = 20;
	localparam int RANDOM_ITEMS = 400;

	localparam int RING_BYTES = BUFFER_BYTES_DEF;
	localparam int REC_MAX    = MAX_RECORD_DEF;
	// full records that fit, then the one short record that takes the last free bytes
	localparam int FILL_RECORDS = (RING_BYTES - 1) / (REC_MAX + 2);
	localparam int TOPUP_LEN    = (RING_BYTES - 1) - FILL_RECORDS * (REC_MAX + 2) - 2;

	localparam logic [2:0] OP_QUERY      = 3'd4;
	localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

	typedef struct {
		bit       drain;
		in_item_t item;
	} backlog_entry_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	in_item_t  cmd = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	out_item_t res;

	backlog_entry_t cmd_backlog[$];
	out_item_t      expected_results[$];

	// shadow copy of the ring and its pointers
	logic [7:0] ring_copy [RING_BYTES];
	int         wr_ptr = 0;
	int         rd_ptr = 0;
	int         pend_ptr = 0;
	int         bytes_left = 0;
	bit         push_open = 1'b0;
	bit         push_rejected = 1'b0;

	int  mismatches = 0;
	int  cycle_count = 0;
	logic cmd_taken = 1'b0;
	int  burst_left = 0;
	int  gap_left = 0;
	int  rx_mode = 0;
	int  rx_mode_left = 0;
	int  rx_hold = 0;

	length_prefixed_record_ring_fifo_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int ring_free();
		int d;
		if (wr_ptr < rd_ptr) d = rd_ptr - wr_ptr;
		else d = rd_ptr + RING_BYTES - wr_ptr;
		return d - 1;
	endfunction

	function automatic void expect_result(logic [2:0] st, logic [7:0] b, int len, logic lst);
		out_item_t r;
		r.status        = st;
		r.out_byte      = b;
		r.stored_length = 7'(len);
		r.free_bytes    = 12'(ring_free());
		r.last          = lst;
		expected_results.push_back(r);
	endfunction

	function automatic void store_byte(logic [7:0] v);
		ring_copy[pend_ptr] = v;
		pend_ptr = (pend_ptr + 1) % RING_BYTES;
	endfunction

	function automatic void ring_step(in_item_t c);
		logic [2:0] st;
		int len;
		int hdr;
		int base;
		case (c.operation)
		OP_PUSH: begin
			st = STS_OK;
			if (c.first_of_record) begin
				len = c.record_length;
				push_open = 1'b1;
				push_rejected = 1'b0;
				bytes_left = (len >= 1) ? len - 1 : 0;
				if (len < 1 || len > REC_MAX) begin
					push_rejected = 1'b1;
					st = STS_OVER;
				end else if (ring_free() < 2 + len) begin
					push_rejected = 1'b1;
					st = STS_NO_SPACE;
				end
				if (push_rejected) begin
					if (bytes_left == 0) push_open = 1'b0;
				end else begin
					pend_ptr = wr_ptr;
					store_byte(8'(len));
					store_byte(8'(len >> 8));
					store_byte(c.data_byte);
				end
			end else if (!push_open) begin
				st = STS_NO_SPACE;
			end else begin
				if (bytes_left > 0) bytes_left--;
				if (push_rejected) begin
					st = STS_NO_SPACE;
					if (bytes_left == 0) push_open = 1'b0;
				end else begin
					store_byte(c.data_byte);
				end
			end
			// commit the record only once its last byte is in
			if (st == STS_OK && bytes_left == 0) begin
				wr_ptr = pend_ptr;
				push_open = 1'b0;
			end
			expect_result(st, 8'h00, 0, 1'b1);
		end
		OP_POP, OP_PEEK: begin
			if (rd_ptr == wr_ptr) begin
				expect_result(STS_EMPTY, 8'h00, 0, 1'b1);
			end else begin
				hdr = {ring_copy[(rd_ptr + 1) % RING_BYTES], ring_copy[rd_ptr]};
				if (hdr < 1 || hdr > REC_MAX) begin
					expect_result(STS_BAD_LEN, 8'h00, 0, 1'b1);
				end else if (c.reader_capacity != 0 && hdr > c.reader_capacity) begin
					expect_result(STS_OVER, 8'h00, hdr, 1'b1);
				end else begin
					base = rd_ptr + 2;
					if (c.operation == OP_POP) rd_ptr = (rd_ptr + 2 + hdr) % RING_BYTES;
					if (c.reader_capacity == 0) begin
						expect_result(STS_OK, 8'h00, hdr, 1'b1);
					end else begin
						for (int i = 0; i < hdr; i++)
							expect_result(STS_OK, ring_copy[(base + i) % RING_BYTES], hdr,
								i == hdr - 1);
					end
				end
			end
		end
		OP_CLEAR: begin
			wr_ptr = 0;
			rd_ptr = 0;
			pend_ptr = 0;
			bytes_left = 0;
			push_open = 1'b0;
			push_rejected = 1'b0;
			expect_result(STS_OK, 8'h00, 0, 1'b1);
		end
		default: begin
			expect_result(STS_OK, 8'h00, 0, 1'b1);
		end
		endcase
	endfunction

	function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
		if (mismatches < 10)
			$display("%s: expected st=%0d byte=%02h len=%0d free=%0d last=%0b, got st=%0d byte=%02h len=%0d free=%0d last=%0b",
				what, want.status, want.out_byte, want.stored_length, want.free_bytes,
				want.last, got.status, got.out_byte, got.stored_length, got.free_bytes,
				got.last);
		mismatches++;
	endfunction

	function automatic void queue_item(logic [2:0] op, logic [7:0] d, logic f, logic [6:0] l,
		logic [6:0] c);
		backlog_entry_t e;
		e.drain                = 1'b0;
		e.item.operation       = op;
		e.item.data_byte       = d;
		e.item.first_of_record = f;
		e.item.record_length   = l;
		e.item.reader_capacity = c;
		cmd_backlog.push_back(e);
	endfunction

	function automatic void queue_drain();
		backlog_entry_t e;
		e.drain = 1'b1;
		e.item  = '0;
		cmd_backlog.push_back(e);
	endfunction

	// non-first push bytes, unused fields random
	function automatic void queue_tail(int n);
		for (int i = 0; i < n; i++)
			queue_item(OP_PUSH, 8'($urandom), 1'b0, 7'($urandom), 7'($urandom));
	endfunction

	function automatic void queue_record(int len, int sent);
		queue_item(OP_PUSH, 8'($urandom), 1'b1, 7'(len), 7'($urandom));
		queue_tail(sent - 1);
	endfunction

	function automatic logic [6:0] pick_capacity();
		case ($urandom_range(0, 3))
		0: return 7'd0;
		1: return 7'h7F;
		2: return 7'(REC_MAX);
		default: return 7'($urandom_range(1, 20));
		endcase
	endfunction

	function automatic void queue_fetch();
		queue_item(($urandom_range(0, 2) != 0) ? OP_POP : OP_PEEK, 8'($urandom),
			1'($urandom), 7'($urandom), pick_capacity());
	endfunction

	// driver: items change on the falling edge, bursts with random gaps
	always @(negedge clk) begin
		backlog_entry_t nxt;
		logic take;
		take = 1'b0;
		nxt.drain = 1'b0;
		nxt.item = '0;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_taken) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_backlog.size() != 0) begin
				if (cmd_backlog[0].drain) begin
					// hold off until every outstanding result is back
					if (expected_results.size() == 0) void'(cmd_backlog.pop_front());
				end else begin
					nxt = cmd_backlog.pop_front();
					take = 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
			cmd_valid <= take;
			if (take) cmd <= nxt.item;
		end
	end

	// receiver: modes of always ready, random ready, and long alternating stretches
	always @(negedge clk) begin
		logic rdy;
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(50, 300);
		end else begin
			rx_mode_left--;
		end
		rdy = res_ready;
		case (rx_mode)
		0: rdy = 1'b1;
		1: rdy = ($urandom_range(0, 3) != 0);
		default: begin
			if (rx_hold == 0) begin
				rdy = ~res_ready;
				rx_hold = $urandom_range(1, 12);
			end else begin
				rx_hold--;
			end
		end
		endcase
		res_ready <= rdy;
	end

	// monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin
		out_item_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("length_prefixed_record_ring_fifo_unit test failed");
			$finish;
		end else begin
			cmd_taken <= arst_n && cmd_valid && cmd_ready;
			if (arst_n && cmd_valid && cmd_ready) ring_step(cmd);
			if (arst_n && res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected result", '0, res);
				end else begin
					want = expected_results.pop_front();
					if (res.status !== want.status || res.out_byte !== want.out_byte
						|| res.stored_length !== want.stored_length
						|| res.free_bytes !== want.free_bytes || res.last !== want.last)
						note_mismatch("result mismatch", want, res);
				end
			end
		end
	end

	initial begin
		int sent;
		int pick;
		int len;
		int k;

		// directed: empty ring, odd operations, bad lengths, capacity corners
		queue_item(OP_POP, 8'h00, 1'b0, 7'd0, 7'd0);
		queue_item(OP_PEEK, 8'hFF, 1'b1, 7'h7F, 7'h7F);
		queue_item(OP_QUERY, 8'h00, 1'b0, 7'd0, 7'd0);
		queue_item(OP_RSVD_FIRST, 8'hFF, 1'b1, 7'h7F, 7'h7F);
		queue_item(OP_RSVD_LAST, 8'h00, 1'b0, 7'd0, 7'd0);
		queue_item(OP_PUSH, 8'hA5, 1'b0, 7'd5, 7'd0);
		queue_record(0, 1);
		queue_record(127, 2);
		queue_item(OP_PUSH, 8'hFF, 1'b1, 7'd1, 7'h7F);
		queue_item(OP_PUSH, 8'h00, 1'b1, 7'd3, 7'd0);
		queue_item(OP_PUSH, 8'hFF, 1'b0, 7'd0, 7'h7F);
		queue_item(OP_PUSH, 8'h80, 1'b0, 7'h7F, 7'd0);
		queue_item(OP_PEEK, 8'h00, 1'b0, 7'd0, 7'd0);
		queue_item(OP_POP, 8'h00, 1'b0, 7'd0, 7'd0);
		queue_item(OP_PEEK, 8'h00, 1'b0, 7'd0, 7'd2);
		queue_item(OP_POP, 8'h00, 1'b0, 7'd0, 7'd3);
		// abandoned by the next first byte
		queue_record(4, 2);
		queue_item(OP_PUSH, 8'h3C, 1'b1, 7'd1, 7'd0);
		// pop in the middle of an open push
		queue_item(OP_PUSH, 8'h5A, 1'b1, 7'd2, 7'd0);
		queue_item(OP_POP, 8'h00, 1'b0, 7'd0, 7'h7F);
		queue_item(OP_PUSH, 8'hC3, 1'b0, 7'd0, 7'd0);
		queue_item(OP_PEEK, 8'h00, 1'b0, 7'd0, 7'(REC_MAX));
		// clear abandons an open push, so the next byte is stray
		queue_item(OP_PUSH, 8'h11, 1'b1, 7'd3, 7'd0);
		queue_item(OP_CLEAR, 8'h00, 1'b0, 7'd0, 7'd0);
		queue_item(OP_PUSH, 8'h22, 1'b0, 7'd3, 7'd0);
		queue_drain();

		// fill to the last byte, then wrap the header across the end of the ring
		queue_item(OP_CLEAR, 8'($urandom), 1'($urandom), 7'($urandom), 7'($urandom));
		repeat (FILL_RECORDS) queue_record(REC_MAX, REC_MAX);
		queue_record(REC_MAX, REC_MAX);
		queue_record(TOPUP_LEN, TOPUP_LEN);
		queue_record(1, 1);
		queue_item(OP_QUERY, 8'($urandom), 1'($urandom), 7'($urandom), 7'($urandom));
		queue_drain();
		repeat (30) queue_fetch();
		repeat (20) begin
			len = $urandom_range(1, REC_MAX);
			queue_record(len, len);
		end
		queue_drain();
		repeat (90) queue_fetch();
		queue_item(OP_CLEAR, 8'($urandom), 1'($urandom), 7'($urandom), 7'($urandom));
		queue_drain();

		// random: mostly whole records, some broken ones and noise
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = ($urandom_range(0, 19) == 0) ? REC_MAX : $urandom_range(1, 16);
				queue_record(len, len);
				sent += len;
			end else if (pick < 75) begin
				queue_fetch();
				sent++;
			end else if (pick < 80) begin
				case ($urandom_range(0, 2))
				0: len = 0;
				1: len = $urandom_range(REC_MAX + 1, 127);
				default: len = $urandom_range(2, 16);
				endcase
				k = (len >= 2 && len <= REC_MAX) ? $urandom_range(1, len - 1)
					: $urandom_range(1, 4);
				queue_record(len, k);
				sent += k;
			end else if (pick < 84) begin
				queue_tail(1);
			end else if (pick < 87) begin
				queue_item(OP_CLEAR, 8'($urandom), 1'($urandom), 7'($urandom),
					7'($urandom));
				sent++;
			end else if (pick < 93) begin
				queue_item(($urandom_range(0, 1) != 0) ? OP_QUERY
					: 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)),
					8'($urandom), 1'($urandom), 7'($urandom), 7'($urandom));
				sent++;
			end else if (pick < 98) begin
				len = $urandom_range(2, 16);
				k = $urandom_range(1, len - 1);
				queue_record(len, k);
				queue_fetch();
				queue_tail(len - k);
				sent += len + 1;
			end else begin
				queue_drain();
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || cmd_valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("length_prefixed_record_ring_fifo_unit test passed");
		end else begin
			$display("length_prefixed_record_ring_fifo_unit test failed");
		end
		$finish;
	end

endmodule
